// ===== design/tlc_pkg.sv =====
// Shared types and constants for the threshold leader clustering block.
// No dependencies; compiled first.
package tlc_pkg;

   localparam int MAX_DIM = 4;
   localparam int COORD_W = 16;
   localparam int IDX_W   = 4;
   localparam int CNT_W   = 16;
   localparam int LS_W    = 32;
   localparam int SS_W    = 48;
   localparam int DIST_W  = 36;
   localparam int PADDR_W = 2;

   localparam logic [PADDR_W-1:0] REG_THRESHOLD   = 2'd0;
   localparam logic [15:0]        THRESHOLD_RESET = 16'd128;
   localparam logic [CNT_W-1:0]   COUNT_MAX       = 16'hFFFF;

   typedef struct packed {
      logic capture;
      logic scan_init;
      logic cur_clr;
      logic cur_inc;
      logic sel_idx;
      logic sq_diff;
      logic sq_point;
      logic compare;
      logic decide;
      logic accum;
      logic div_start;
      logic div_radius;
      logic write;
      logic load_assign;
      logic mul_clr;
      logic mul;
      logic mul_acc;
      logic sub;
      logic sqrt_start;
      logic load_report;
      logic clear_used;
   } tlc_cmd_type;

   typedef struct packed {
      logic used_zero;
      logic cur_last;
      logic found;
      logic full;
      logic sat;
      logic div_busy;
      logic sqrt_busy;
      logic mul_last;
      logic last_point;
   } tlc_status_type;

   typedef struct packed {
      logic              kind;
      logic [IDX_W-1:0]  cluster_index;
      logic              created;
      logic              dropped;
      logic [CNT_W-1:0]  member_count;
      logic [15:0]       radius;
      logic              final_result;
   } tlc_rsp_type;

endpackage

// ===== design/tlc_req_if.sv =====
// Request channel: one point of up to four Q8.8 coordinates plus last flag.
// Standalone; no package dependency.
interface tlc_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] coord_0;
   logic signed [15:0] coord_1;
   logic signed [15:0] coord_2;
   logic signed [15:0] coord_3;
   logic               last_point;

   modport source (output valid, coord_0, coord_1, coord_2, coord_3, last_point,
                   input ready);
   modport sink   (input valid, coord_0, coord_1, coord_2, coord_3, last_point,
                   output ready);
endinterface

// ===== design/tlc_rsp_if.sv =====
// Result channel: assignment and subcluster report items.
// Standalone; no package dependency.
interface tlc_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [3:0]  cluster_index;
   logic        created;
   logic        dropped;
   logic [15:0] member_count;
   logic [15:0] radius;
   logic        final_result;

   modport source (output valid, kind, cluster_index, created, dropped, member_count,
                   radius, final_result, input ready);
   modport sink   (input valid, kind, cluster_index, created, dropped, member_count,
                   radius, final_result, output ready);
endinterface

// ===== design/tlc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tlc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== design/tlc_div.sv =====
// Restoring divider, 32-bit unsigned dividend by 16-bit divisor, one bit per cycle.
// Uses nothing outside this file.
module tlc_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [15:0] divisor,
   output logic        busy,
   output logic [31:0] quotient
);
   logic        busy_ff, busy_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [15:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [15:0] dvs_ff, dvs_in;
   logic [16:0] trial;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      trial   = {rem_ff, quo_ff[31]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = 16'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = trial[15:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;
endmodule

// ===== design/tlc_isqrt.sv =====
// Bit-pair integer square root of a 64-bit value, giving a 32-bit root.
// Uses nothing outside this file.
module tlc_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        busy,
   output logic [31:0] root
);
   logic        busy_ff, busy_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] res_ff, res_in;
   logic [63:0] bit_ff, bit_in;
   logic [63:0] trial;

   always_comb begin
      busy_in = busy_ff;
      rem_in  = rem_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      trial   = res_ff + bit_ff;
      if (start) begin
         busy_in = 1'b1;
         rem_in  = radicand;
         res_in  = '0;
         bit_in  = 64'h4000_0000_0000_0000;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign busy = busy_ff;
   assign root = res_ff[31:0];
endmodule

// ===== design/tlc_datapath.sv =====
// Clustering datapath: subcluster tables, distance lanes, dividers, report math.
// Depends on tlc_pkg, tlc_ram, tlc_div and tlc_isqrt.
module tlc_datapath #(
   parameter int DIM             = 4,
   parameter int MAX_SUBCLUSTERS = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  tlc_pkg::tlc_cmd_type                      cmd,
   output tlc_pkg::tlc_status_type                   st,
   input  logic [15:0]                               threshold,
   input  logic [tlc_pkg::MAX_DIM*tlc_pkg::COORD_W-1:0] coords_in,
   input  logic                                      last_in,
   output tlc_pkg::tlc_rsp_type                      rsp
);
   import tlc_pkg::*;

   localparam int CW = (MAX_SUBCLUSTERS > 1) ? $clog2(MAX_SUBCLUSTERS) : 1;
   localparam int UW = $clog2(MAX_SUBCLUSTERS + 1);
   localparam int SW = $clog2(DIM + 2);
   localparam logic [UW-1:0] USED_MAX  = UW'(MAX_SUBCLUSTERS);
   localparam logic [SW-1:0] STEP_LAST = SW'(DIM + 1);

   logic signed [COORD_W-1:0] point_ff [DIM];
   logic                      last_ff;
   logic [UW-1:0]             used_ff, used_in;
   logic [CW-1:0]             cur_ff, cur_in;
   logic [CW-1:0]             idx_ff, idx_in;
   logic [DIST_W-1:0]         best_ff, best_in;
   logic                      found_ff, found_in;
   logic                      create_ff, create_in;
   logic                      drop_ff, drop_in;
   logic [33:0]               sq_ff [DIM];
   logic [33:0]               sq_in [DIM];
   logic [CNT_W-1:0]          ncnt_ff, ncnt_in;
   logic signed [LS_W-1:0]    nls_ff [DIM];
   logic signed [LS_W-1:0]    nls_in [DIM];
   logic [SS_W-1:0]           nss_ff, nss_in;
   logic [63:0]               prod_ff, tot_ff, tot_in, ls2_ff, ls2_in, x_ff;
   logic [SW-1:0]             step_ff, step_in;
   tlc_rsp_type               rsp_ff, rsp_in;

   logic [CW-1:0]              addr;
   logic [CNT_W-1:0]           cnt_rd;
   logic [DIM*LS_W-1:0]        ls_rd;
   logic [SS_W-1:0]            ss_rd;
   logic [DIM*COORD_W-1:0]     cen_rd;
   logic [DIM*LS_W-1:0]        ls_wr;
   logic [DIM*COORD_W-1:0]     cen_wr;

   logic signed [COORD_W-1:0]  opb [DIM];
   logic signed [16:0]         diff [DIM];
   logic signed [33:0]         sqp [DIM];
   logic [DIST_W-1:0]          dist_sum;
   logic [SS_W-1:0]            ss_add;
   logic [31:0]                ls_abs [DIM];
   logic [31:0]                mul_a, mul_b;
   logic [31:0]                div_dvd [DIM];
   logic [31:0]                quo [DIM];
   logic [DIM-1:0]             div_busy;
   logic [15:0]                div_dvs;
   logic [31:0]                root;
   logic                       sqrt_busy;
   logic                       cur_last;
   logic [15:0]                radius;

   assign addr = cmd.sel_idx ? idx_ff : cur_ff;

   tlc_ram #(.WIDTH(CNT_W), .DEPTH(MAX_SUBCLUSTERS)) u_cnt_ram (
      .clock(clock), .we(cmd.write), .waddr(idx_ff), .wdata(ncnt_ff),
      .raddr(addr), .rdata(cnt_rd));
   tlc_ram #(.WIDTH(DIM*LS_W), .DEPTH(MAX_SUBCLUSTERS)) u_ls_ram (
      .clock(clock), .we(cmd.write), .waddr(idx_ff), .wdata(ls_wr),
      .raddr(addr), .rdata(ls_rd));
   tlc_ram #(.WIDTH(SS_W), .DEPTH(MAX_SUBCLUSTERS)) u_ss_ram (
      .clock(clock), .we(cmd.write), .waddr(idx_ff), .wdata(nss_ff),
      .raddr(addr), .rdata(ss_rd));
   tlc_ram #(.WIDTH(DIM*COORD_W), .DEPTH(MAX_SUBCLUSTERS)) u_cen_ram (
      .clock(clock), .we(cmd.write), .waddr(idx_ff), .wdata(cen_wr),
      .raddr(addr), .rdata(cen_rd));

   // Per-lane squared difference; the centroid operand is zero for point squares.
   always_comb begin
      for (int d = 0; d < DIM; d++) begin
         opb[d]  = cmd.sq_point ? 16'sd0 : signed'(cen_rd[d*COORD_W +: COORD_W]);
         diff[d] = 17'(point_ff[d]) - 17'(opb[d]);
         sqp[d]  = diff[d] * diff[d];
         sq_in[d] = unsigned'(sqp[d]);
         ls_abs[d] = ls_rd[d*LS_W + LS_W-1] ? 32'(-signed'(ls_rd[d*LS_W +: LS_W]))
                                            : ls_rd[d*LS_W +: LS_W];
      end
   end

   always_comb begin
      dist_sum = '0;
      ss_add   = create_ff ? '0 : ss_rd;
      for (int d = 0; d < DIM; d++) begin
         dist_sum = dist_sum + DIST_W'(sq_ff[d]);
         ss_add   = ss_add + SS_W'(sq_ff[d]);
      end
   end

   assign cur_last = (UW'(cur_ff) + UW'(1)) == used_ff;

   // Multiply operands: N times SS in two halves, then each linear sum squared.
   always_comb begin
      mul_a = 32'(cnt_rd);
      mul_b = ss_rd[31:0];
      if (step_ff == SW'(1)) begin
         mul_b = 32'(ss_rd[SS_W-1:32]);
      end
      for (int d = 0; d < DIM; d++) begin
         if (step_ff == SW'(d + 2)) begin
            mul_a = ls_abs[d];
            mul_b = ls_abs[d];
         end
      end
   end

   always_comb begin
      used_in   = used_ff;
      cur_in    = cur_ff;
      idx_in    = idx_ff;
      best_in   = best_ff;
      found_in  = found_ff;
      create_in = create_ff;
      drop_in   = drop_ff;
      ncnt_in   = ncnt_ff;
      nss_in    = nss_ff;
      tot_in    = tot_ff;
      ls2_in    = ls2_ff;
      step_in   = step_ff;
      for (int d = 0; d < DIM; d++) begin
         nls_in[d] = nls_ff[d];
      end
      if (cmd.scan_init) begin
         best_in   = DIST_W'(threshold) * DIST_W'(threshold);
         found_in  = 1'b0;
         create_in = 1'b0;
         drop_in   = 1'b0;
         idx_in    = '0;
      end
      if (cmd.cur_clr) begin
         cur_in = '0;
      end else if (cmd.cur_inc) begin
         cur_in = cur_ff + CW'(1);
      end
      if (cmd.compare && dist_sum < best_ff) begin
         best_in  = dist_sum;
         found_in = 1'b1;
         idx_in   = cur_ff;
      end
      if (cmd.decide && !found_ff) begin
         if (used_ff != USED_MAX) begin
            idx_in    = used_ff[CW-1:0];
            create_in = 1'b1;
         end else begin
            drop_in = 1'b1;
         end
      end
      if (cmd.accum) begin
         ncnt_in = (create_ff ? '0 : cnt_rd) + CNT_W'(1);
         nss_in  = ss_add;
         for (int d = 0; d < DIM; d++) begin
            nls_in[d] = (create_ff ? 32'sd0 : signed'(ls_rd[d*LS_W +: LS_W]))
                        + LS_W'(point_ff[d]);
         end
      end
      if (cmd.write && create_ff) begin
         used_in = used_ff + UW'(1);
      end
      if (cmd.clear_used) begin
         used_in = '0;
      end
      if (cmd.mul_clr) begin
         step_in = '0;
      end else if (cmd.mul_acc) begin
         step_in = step_ff + SW'(1);
         if (step_ff == SW'(0)) begin
            tot_in = prod_ff;
         end else if (step_ff == SW'(1)) begin
            tot_in = tot_ff + {prod_ff[31:0], 32'd0};
         end else if (step_ff == SW'(2)) begin
            ls2_in = prod_ff;
         end else begin
            ls2_in = ls2_ff + prod_ff;
         end
      end
   end

   always_comb begin
      div_dvs = cmd.div_radius ? cnt_rd : ncnt_ff;
      for (int d = 0; d < DIM; d++) begin
         div_dvd[d] = nls_ff[d][LS_W-1] ? 32'(-nls_ff[d]) : 32'(nls_ff[d]);
         cen_wr[d*COORD_W +: COORD_W] = nls_ff[d][LS_W-1] ? 16'(-quo[d][15:0])
                                                          : quo[d][15:0];
         ls_wr[d*LS_W +: LS_W] = nls_ff[d];
      end
      if (cmd.div_radius) begin
         div_dvd[0] = root;
      end
   end

   for (genvar g = 0; g < DIM; g++) begin : g_div
      tlc_div u_div (
         .clock(clock), .reset(reset), .start(cmd.div_start),
         .dividend(div_dvd[g]), .divisor(div_dvs),
         .busy(div_busy[g]), .quotient(quo[g]));
   end

   tlc_isqrt u_isqrt (
      .clock(clock), .reset(reset), .start(cmd.sqrt_start),
      .radicand(x_ff), .busy(sqrt_busy), .root(root));

   assign radius = (cnt_rd <= CNT_W'(1)) ? 16'd0 :
                   (quo[0] > 32'd65535) ? 16'hFFFF : quo[0][15:0];

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.load_assign) begin
         rsp_in.kind          = 1'b0;
         rsp_in.cluster_index = IDX_W'(idx_ff);
         rsp_in.created       = create_ff;
         rsp_in.dropped       = drop_ff;
         rsp_in.member_count  = '0;
         rsp_in.radius        = '0;
         rsp_in.final_result  = !last_ff || (used_ff == '0);
      end else if (cmd.load_report) begin
         rsp_in.kind          = 1'b1;
         rsp_in.cluster_index = IDX_W'(cur_ff);
         rsp_in.created       = 1'b0;
         rsp_in.dropped       = 1'b0;
         rsp_in.member_count  = cnt_rd;
         rsp_in.radius        = radius;
         rsp_in.final_result  = cur_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
      if (cmd.capture) begin
         for (int d = 0; d < DIM; d++) begin
            point_ff[d] <= signed'(coords_in[d*COORD_W +: COORD_W]);
         end
         last_ff <= last_in;
      end
      if (cmd.sq_diff || cmd.sq_point) begin
         for (int d = 0; d < DIM; d++) begin
            sq_ff[d] <= sq_in[d];
         end
      end
      if (cmd.mul) begin
         prod_ff <= mul_a * mul_b;
      end
      if (cmd.sub) begin
         x_ff <= (tot_ff > ls2_ff) ? tot_ff - ls2_ff : 64'd0;
      end
      for (int d = 0; d < DIM; d++) begin
         nls_ff[d] <= nls_in[d];
      end
      cur_ff    <= cur_in;
      idx_ff    <= idx_in;
      best_ff   <= best_in;
      found_ff  <= found_in;
      create_ff <= create_in;
      drop_ff   <= drop_in;
      ncnt_ff   <= ncnt_in;
      nss_ff    <= nss_in;
      tot_ff    <= tot_in;
      ls2_ff    <= ls2_in;
      step_ff   <= step_in;
      rsp_ff    <= rsp_in;
   end

   assign st.used_zero  = (used_ff == '0);
   assign st.cur_last   = cur_last;
   assign st.found      = found_ff;
   assign st.full       = (used_ff == USED_MAX);
   assign st.sat        = found_ff && (cnt_rd == COUNT_MAX);
   assign st.div_busy   = div_busy[0];
   assign st.sqrt_busy  = sqrt_busy;
   assign st.mul_last   = (step_ff == STEP_LAST);
   assign st.last_point = last_ff;
   assign rsp           = rsp_ff;
endmodule

// ===== design/tlc_ctrl.sv =====
// Sequencer for scan, update, assignment and report phases.
// Depends on tlc_pkg; drives tlc_datapath through command/status structs.
module tlc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  tlc_pkg::tlc_status_type st,
   output tlc_pkg::tlc_cmd_type    cmd
);
   import tlc_pkg::*;

   localparam logic [4:0] S_IDLE      = 5'd0;
   localparam logic [4:0] S_SC_RD     = 5'd1;
   localparam logic [4:0] S_SC_SQ     = 5'd2;
   localparam logic [4:0] S_SC_CMP    = 5'd3;
   localparam logic [4:0] S_DECIDE    = 5'd4;
   localparam logic [4:0] S_UP_RD     = 5'd5;
   localparam logic [4:0] S_UP_SQ     = 5'd6;
   localparam logic [4:0] S_UP_SUM    = 5'd7;
   localparam logic [4:0] S_DIV_GO    = 5'd8;
   localparam logic [4:0] S_DIV_WAIT  = 5'd9;
   localparam logic [4:0] S_WRITE     = 5'd10;
   localparam logic [4:0] S_ASSIGN    = 5'd11;
   localparam logic [4:0] S_EMIT_A    = 5'd12;
   localparam logic [4:0] S_RP_RD     = 5'd13;
   localparam logic [4:0] S_RP_MUL    = 5'd14;
   localparam logic [4:0] S_RP_ACC    = 5'd15;
   localparam logic [4:0] S_RP_SUB    = 5'd16;
   localparam logic [4:0] S_SQ_GO     = 5'd17;
   localparam logic [4:0] S_SQ_WAIT   = 5'd18;
   localparam logic [4:0] S_RDIV_GO   = 5'd19;
   localparam logic [4:0] S_RDIV_WAIT = 5'd20;
   localparam logic [4:0] S_RP_LOAD   = 5'd21;
   localparam logic [4:0] S_EMIT_R    = 5'd22;

   logic [4:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture   = 1'b1;
               cmd.scan_init = 1'b1;
               cmd.cur_clr   = 1'b1;
               state_in = st.used_zero ? S_DECIDE : S_SC_RD;
            end
         end
         S_SC_RD: state_in = S_SC_SQ;
         S_SC_SQ: begin
            cmd.sq_diff = 1'b1;
            state_in = S_SC_CMP;
         end
         S_SC_CMP: begin
            cmd.compare = 1'b1;
            if (st.cur_last) begin
               state_in = S_DECIDE;
            end else begin
               cmd.cur_inc = 1'b1;
               state_in = S_SC_RD;
            end
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            state_in = (!st.found && st.full) ? S_ASSIGN : S_UP_RD;
         end
         S_UP_RD: begin
            cmd.sel_idx = 1'b1;
            state_in = S_UP_SQ;
         end
         S_UP_SQ: begin
            cmd.sel_idx  = 1'b1;
            cmd.sq_point = 1'b1;
            state_in = S_UP_SUM;
         end
         S_UP_SUM: begin
            cmd.sel_idx = 1'b1;
            cmd.accum   = 1'b1;
            // a full subcluster keeps its statistics frozen
            state_in = st.sat ? S_ASSIGN : S_DIV_GO;
         end
         S_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (!st.div_busy) begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            cmd.sel_idx = 1'b1;
            cmd.write   = 1'b1;
            state_in = S_ASSIGN;
         end
         S_ASSIGN: begin
            cmd.load_assign = 1'b1;
            state_in = S_EMIT_A;
         end
         S_EMIT_A: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (st.last_point && !st.used_zero) begin
                  cmd.cur_clr = 1'b1;
                  state_in = S_RP_RD;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_RP_RD: begin
            cmd.mul_clr = 1'b1;
            state_in = S_RP_MUL;
         end
         S_RP_MUL: begin
            cmd.mul = 1'b1;
            state_in = S_RP_ACC;
         end
         S_RP_ACC: begin
            cmd.mul_acc = 1'b1;
            state_in = st.mul_last ? S_RP_SUB : S_RP_MUL;
         end
         S_RP_SUB: begin
            cmd.sub = 1'b1;
            state_in = S_SQ_GO;
         end
         S_SQ_GO: begin
            cmd.sqrt_start = 1'b1;
            state_in = S_SQ_WAIT;
         end
         S_SQ_WAIT: begin
            if (!st.sqrt_busy) begin
               state_in = S_RDIV_GO;
            end
         end
         S_RDIV_GO: begin
            cmd.div_start  = 1'b1;
            cmd.div_radius = 1'b1;
            state_in = S_RDIV_WAIT;
         end
         S_RDIV_WAIT: begin
            if (!st.div_busy) begin
               state_in = S_RP_LOAD;
            end
         end
         S_RP_LOAD: begin
            cmd.load_report = 1'b1;
            state_in = S_EMIT_R;
         end
         S_EMIT_R: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (st.cur_last) begin
                  cmd.clear_used = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  cmd.cur_inc = 1'b1;
                  state_in = S_RP_RD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff != S_IDLE)
      else $error("sequencer idle right after taking a request");
   a_div_restart: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !st.div_busy)
      else $error("divider started while busy");
   a_sqrt_restart: assert property (@(posedge clock) disable iff (reset)
      cmd.sqrt_start |-> !st.sqrt_busy)
      else $error("square root started while busy");
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> state_ff == $past(state_ff))
      else $error("result dropped while stalled");
endmodule

// ===== design/threshold_leader_clustering_top.sv =====
// Threshold leader clustering with clustering-feature statistics per subcluster.
//
// Channels: req_chan takes one point (coord_0..coord_3, signed Q8.8, plus
// last_point); rsp_chan returns one assignment per point and, after a point
// marked last, one report per open subcluster (count, radius) in index order,
// the final one flagged by final_result. The table is empty after the reports.
// The APB port holds threshold_distance at byte address 0 (reset 128).
//
// Sequencing: a request is taken only when the sequencer is idle. The scan
// visits each open subcluster in turn (table RAM read, square, compare), and
// an update of the chosen subcluster runs the centroid division. Each report
// then runs the shared 32x32 multiplier, the square root and the divide one
// after another.
//
// Reset (synchronous) empties the table and restores the threshold. A stalled
// result holds on rsp_chan and the sequencer waits; no request is taken then.
module threshold_leader_clustering_top #(
   parameter int DIM             = 4,
   parameter int MAX_SUBCLUSTERS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   tlc_req_if.sink                       req_chan,
   tlc_rsp_if.source                     rsp_chan,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [tlc_pkg::PADDR_W-1:0]   paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   import tlc_pkg::*;

   logic [15:0]                  thr_ff, thr_in;
   logic [MAX_DIM*COORD_W-1:0]   coords;
   tlc_cmd_type                  cmd;
   tlc_status_type               st;
   tlc_rsp_type                  rsp;

   always_comb begin
      thr_in = thr_ff;
      if (psel && penable && pwrite && paddr == REG_THRESHOLD) begin
         thr_in = pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THRESHOLD_RESET;
      end else begin
         thr_ff <= thr_in;
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr == REG_THRESHOLD) ? {16'd0, thr_ff} : 32'd0;

   assign coords = {req_chan.coord_3, req_chan.coord_2, req_chan.coord_1, req_chan.coord_0};

   tlc_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_chan.valid), .req_ready(req_chan.ready),
      .rsp_valid(rsp_chan.valid), .rsp_ready(rsp_chan.ready),
      .st(st), .cmd(cmd));

   tlc_datapath #(.DIM(DIM), .MAX_SUBCLUSTERS(MAX_SUBCLUSTERS)) u_datapath (
      .clock(clock), .reset(reset), .cmd(cmd), .st(st), .threshold(thr_ff),
      .coords_in(coords), .last_in(req_chan.last_point), .rsp(rsp));

   assign rsp_chan.kind          = rsp.kind;
   assign rsp_chan.cluster_index = rsp.cluster_index;
   assign rsp_chan.created       = rsp.created;
   assign rsp_chan.dropped       = rsp.dropped;
   assign rsp_chan.member_count  = rsp.member_count;
   assign rsp_chan.radius        = rsp.radius;
   assign rsp_chan.final_result  = rsp.final_result;
endmodule
